// File: rtl/fsoe_pkg.sv
// Shared types, character constants and helper functions of the format output engine.
`default_nettype none

package fsoe_pkg;

    // Character codes
    localparam logic [7:0] C_NUL   = 8'h00;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_PCT   = 8'h25;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [7:0] C_UC_A  = 8'h41;
    localparam logic [7:0] C_UC_X  = 8'h58;
    localparam logic [7:0] C_LC_A  = 8'h61;
    localparam logic [7:0] C_LC_C  = 8'h63;
    localparam logic [7:0] C_LC_D  = 8'h64;
    localparam logic [7:0] C_LC_S  = 8'h73;
    localparam logic [7:0] C_LC_X  = 8'h78;

    // Commands from the sequencer to the digit unit
    typedef struct packed {
        logic load_bin;  // start a binary to BCD conversion of the word
        logic load_hex;  // load the word as hex digits
        logic shift;     // drop the top digit
    } t_dig_ctl;

    // Status of the digit unit
    typedef struct packed {
        logic       busy;     // conversion still running
        logic [3:0] digit;    // current top digit
        logic       rem_one;  // the top digit is the last one
    } t_dig_sts;

    // Bytes of the UTF-8 bomb marker, in output order
    function automatic logic [7:0] bomb_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'hF0;
            2'd1:    b = 8'h9F;
            2'd2:    b = 8'h92;
            default: b = 8'hA3;
        endcase
        return b;
    endfunction

    // ASCII character of one digit, hex letters in either case
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        logic [7:0] c;
        base = upper ? C_UC_A : C_LC_A;
        if (d < 4'd10) begin
            c = C_ZERO + {4'd0, d};
        end else begin
            c = base + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/format_string_output_engine.sv
// Top level of the format output engine: decode, sequencing and output register.
`default_nettype none

// One format byte enters per item together with an argument word, and the
// engine sends out zero or more bytes, the final byte of each item marked
// with o_last. For %d the bit-serial binary to BCD converter shifts one
// argument bit per cycle, and the digit shift register, which holds NDIG =
// max(3*ARG_BITS/10+1, ceil(ARG_BITS/4)) digits (10 for 32 bits), skips or
// sends one digit per cycle, a sent digit only while the output register is
// free. A new item is taken once the previous one has placed its final
// byte in the output register, even if that byte has not yet been taken
// downstream.
module format_string_output_engine #(
    parameter int ARG_BITS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [7:0]         i_fmt_char,
    input  wire logic signed [31:0] i_arg_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [7:0]              o_out_char,
    output logic                    o_last
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_BYTE   = 6'b000010,
        S_BOMB   = 6'b000100,
        S_CONV   = 6'b001000,
        S_SIGN   = 6'b010000,
        S_DIGITS = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_in_format, n_in_format;
    logic   r_after_cr, n_after_cr;
    logic   r_neg, n_neg;
    logic   r_upper, n_upper;
    logic   r_lead, n_lead;
    logic [1:0] r_cnt, n_cnt;
    logic [7:0] r_byte, n_byte;

    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_last;

    logic [ARG_BITS-1:0] w;
    logic [ARG_BITS-1:0] neg_w;
    logic [ARG_BITS-1:0] dig_word;
    logic                in_acc;
    logic                out_free;
    logic                push;
    logic [7:0]          push_char;
    logic                push_last;
    logic                swallow;

    fsoe_pkg::t_dig_ctl dig_ctl;
    fsoe_pkg::t_dig_sts dig_sts;

    // Sign-extend or cut the argument to an ARG_BITS two's complement word
    generate
        if (ARG_BITS > 32) begin : g_ext
            assign w = {{(ARG_BITS-32){i_arg_value[31]}}, i_arg_value};
        end else begin : g_cut
            assign w = i_arg_value[ARG_BITS-1:0];
        end
    endgenerate

    // Magnitude for %d; the most negative value stays correct as unsigned
    assign neg_w    = ~w + {{(ARG_BITS-1){1'b0}}, 1'b1};
    assign dig_word = dig_ctl.load_bin ? (w[ARG_BITS-1] ? neg_w : w) : w;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign swallow    = r_after_cr && (i_fmt_char == fsoe_pkg::C_LF ||
                                       i_fmt_char == fsoe_pkg::C_CR);

    fsoe_digits #(
        .ARG_BITS (ARG_BITS)
    ) u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dig_ctl),
        .i_word  (dig_word),
        .o_sts   (dig_sts)
    );

    // Sequencer: decode an item, then hand out its bytes one per push
    always_comb begin
        n_state     = r_state;
        n_in_format = r_in_format;
        n_after_cr  = r_after_cr;
        n_neg       = r_neg;
        n_upper     = r_upper;
        n_lead      = r_lead;
        n_cnt       = r_cnt;
        n_byte      = r_byte;
        push        = 1'b0;
        push_char   = r_byte;
        push_last   = 1'b0;
        dig_ctl     = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_fmt_char == fsoe_pkg::C_NUL) begin
                        // End of string: drop both modes, emit nothing
                        n_in_format = 1'b0;
                        n_after_cr  = 1'b0;
                    end else if (r_in_format) begin
                        n_in_format = 1'b0;
                        n_after_cr  = 1'b0;
                        case (i_fmt_char)
                            fsoe_pkg::C_PCT: begin
                                n_byte  = fsoe_pkg::C_PCT;
                                n_state = S_BYTE;
                            end
                            fsoe_pkg::C_LC_C: begin
                                n_byte  = i_arg_value[7:0];
                                n_state = S_BYTE;
                            end
                            fsoe_pkg::C_LC_D: begin
                                dig_ctl.load_bin = 1'b1;
                                n_neg   = w[ARG_BITS-1];
                                n_upper = 1'b0;
                                n_lead  = 1'b1;
                                n_state = S_CONV;
                            end
                            fsoe_pkg::C_LC_X: begin
                                dig_ctl.load_hex = 1'b1;
                                n_upper = 1'b0;
                                n_lead  = 1'b1;
                                n_state = S_DIGITS;
                            end
                            fsoe_pkg::C_UC_X: begin
                                dig_ctl.load_hex = 1'b1;
                                n_upper = 1'b1;
                                n_lead  = 1'b1;
                                n_state = S_DIGITS;
                            end
                            fsoe_pkg::C_LC_S: begin
                                // String conversion is not supported: emit nothing
                                n_state = S_IDLE;
                            end
                            default: begin
                                n_cnt   = 2'd0;
                                n_state = S_BOMB;
                            end
                        endcase
                    end else begin
                        n_after_cr = 1'b0;
                        if (!swallow) begin
                            if (i_fmt_char == fsoe_pkg::C_PCT) begin
                                n_in_format = 1'b1;
                            end else if (i_fmt_char == fsoe_pkg::C_CR) begin
                                // CR goes out as LF and arms the swallow
                                n_byte     = fsoe_pkg::C_LF;
                                n_after_cr = 1'b1;
                                n_state    = S_BYTE;
                            end else begin
                                n_byte  = i_fmt_char;
                                n_state = S_BYTE;
                            end
                        end
                    end
                end
            end
            S_BYTE: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_char = r_byte;
                    push_last = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_BOMB: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_char = fsoe_pkg::bomb_byte(r_cnt);
                    push_last = (r_cnt == 2'd3);
                    n_cnt     = r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_CONV: begin
                // Wait for the converter to shift in every argument bit
                if (!dig_sts.busy) begin
                    n_state = r_neg ? S_SIGN : S_DIGITS;
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_char = fsoe_pkg::C_MINUS;
                    n_state   = S_DIGITS;
                end
            end
            S_DIGITS: begin
                if (r_lead && dig_sts.digit == 4'd0 && !dig_sts.rem_one) begin
                    // Skip a leading zero; the last digit always goes out
                    dig_ctl.shift = 1'b1;
                end else if (out_free) begin
                    push          = 1'b1;
                    push_char     = fsoe_pkg::digit_char(dig_sts.digit, r_upper);
                    push_last     = dig_sts.rem_one;
                    dig_ctl.shift = 1'b1;
                    n_lead        = 1'b0;
                    if (dig_sts.rem_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_format <= 1'b0;
            r_after_cr  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_format <= n_in_format;
            r_after_cr  <= n_after_cr;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: the output byte and its last flag hold until the next push
    always_ff @(posedge i_clk) begin
        r_neg   <= n_neg;
        r_upper <= n_upper;
        r_lead  <= n_lead;
        r_cnt   <= n_cnt;
        r_byte  <= n_byte;
        if (push) begin
            r_out_char <= push_char;
            r_out_last <= push_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last      = r_out_last;

    // Format mode and the CR swallow are never armed together
    a_modes_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_format |-> !r_after_cr)
        else $error("format mode and CR swallow both set");

    // No item is taken while the converter is still running
    a_accept_idle_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> !dig_sts.busy)
        else $error("item accepted during conversion");

    // Digits are only read from a finished conversion
    a_digits_after_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIGITS) |-> !dig_sts.busy)
        else $error("digit read while converter busy");

    // The final digit of a number is marked last
    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIGITS && push && dig_sts.rem_one) |=> (o_out_valid && o_last))
        else $error("final digit not marked last");

endmodule

`default_nettype wire

// File: rtl/fsoe_digits.sv
// Digit unit: bit-serial binary to BCD conversion and a digit shift register.
`default_nettype none

module fsoe_digits #(
    parameter int ARG_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire fsoe_pkg::t_dig_ctl   i_ctl,
    input  wire logic [ARG_BITS-1:0]  i_word,
    output fsoe_pkg::t_dig_sts        o_sts
);

    localparam int NDEC = (ARG_BITS * 3) / 10 + 1;
    localparam int NHEX = (ARG_BITS + 3) / 4;
    localparam int NDIG = (NDEC > NHEX) ? NDEC : NHEX;
    localparam int W    = NDIG * 4;
    localparam int CW   = $clog2(ARG_BITS + 1);
    localparam int RW   = $clog2(NDIG + 1);

    logic [W-1:0]        r_bcd;
    logic [ARG_BITS-1:0] r_bin;
    logic [CW-1:0]       r_bits;
    logic [RW-1:0]       r_rem;
    logic [W-1:0]        adj;

    // Add three to every digit of five or more before the next shift
    always_comb begin
        for (int k = 0; k < NDIG; k++) begin
            adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? r_bcd[4*k +: 4] + 4'd3
                                                       : r_bcd[4*k +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
            r_rem  <= '0;
        end else if (i_ctl.load_bin) begin
            r_bits <= CW'(ARG_BITS);
            r_rem  <= RW'(NDIG);
        end else if (i_ctl.load_hex) begin
            r_bits <= '0;
            r_rem  <= RW'(NDIG);
        end else if (r_bits != '0) begin
            r_bits <= r_bits - CW'(1);
        end else if (i_ctl.shift) begin
            r_rem  <= r_rem - RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_bin) begin
            r_bin <= i_word;
            r_bcd <= '0;
        end else if (i_ctl.load_hex) begin
            r_bcd <= W'(i_word);
        end else if (r_bits != '0) begin
            r_bcd <= {adj[W-2:0], r_bin[ARG_BITS-1]};
            r_bin <= r_bin << 1;
        end else if (i_ctl.shift) begin
            r_bcd <= r_bcd << 4;
        end
    end

    assign o_sts.busy    = (r_bits != '0);
    assign o_sts.digit   = r_bcd[W-1 -: 4];
    assign o_sts.rem_one = (r_rem == RW'(1));

endmodule

`default_nettype wire

// File: sim/format_string_output_engine_tb.sv
// Self-checking testbench of the format output engine, with predictor and scoreboard.
`default_nettype none

module format_string_output_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Run limits: the cycle budget is many times the slowest correct run,
    // and the settle time covers a full %d conversion with some margin.
    localparam int CYCLE_LIMIT   = 250000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 100;
    localparam int RANDOM_ITEMS  = 90;

    // Four bytes of the UTF-8 bomb marker, first byte in the top lane
    localparam logic [31:0] BOMB_MARKER = 32'hF09F92A3;

    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_last;
    } t_emitted;

    // Output stall patterns of the receiver
    typedef enum int {RX_OPEN, RX_COIN, RX_SLOW, RX_MOSTLY} t_rx_mode;

    // Predict the byte stream of the engine and check the bytes it sends.
    class format_checker;
        logic       in_fmt;
        logic       cr_seen;
        t_emitted   pending_bytes[$];
        logic [7:0] staged[$];
        int         errors;
        int         items_seen;
        int         conversions;
        int         swallowed;
        int         bytes_checked;

        function new();
            in_fmt        = 1'b0;
            cr_seen       = 1'b0;
            errors        = 0;
            items_seen    = 0;
            conversions   = 0;
            swallowed     = 0;
            bytes_checked = 0;
        endfunction

        function int pending();
            return pending_bytes.size();
        endfunction

        // Stage the digits of a magnitude, most significant first, no leading zeros.
        function void stage_number(logic [31:0] mag, int unsigned radix, logic upper);
            logic [7:0]  digs[$];
            logic [31:0] dv;
            logic [7:0]  letter;
            letter = upper ? fsoe_pkg::C_UC_A : fsoe_pkg::C_LC_A;
            do begin
                dv = mag % radix;
                if (dv < 10) begin
                    digs.push_front(8'(fsoe_pkg::C_ZERO + dv));
                end else begin
                    digs.push_front(8'(letter + dv - 10));
                end
                mag = mag / radix;
            end while (mag != 0);
            foreach (digs[i]) staged.push_back(digs[i]);
        endfunction

        // Note one accepted item and queue the bytes it must produce.
        function void take_item(logic [7:0] ch, logic [31:0] arg);
            logic swallow;
            items_seen++;
            staged.delete();
            if (ch == fsoe_pkg::C_NUL) begin
                in_fmt  = 1'b0;
                cr_seen = 1'b0;
            end else if (in_fmt) begin
                in_fmt  = 1'b0;
                cr_seen = 1'b0;
                conversions++;
                case (ch)
                    fsoe_pkg::C_PCT:  staged.push_back(fsoe_pkg::C_PCT);
                    fsoe_pkg::C_LC_C: staged.push_back(arg[7:0]);
                    fsoe_pkg::C_LC_D: begin
                        if (arg[31]) begin
                            staged.push_back(fsoe_pkg::C_MINUS);
                            stage_number(~arg + 32'd1, 10, 1'b0);
                        end else begin
                            stage_number(arg, 10, 1'b0);
                        end
                    end
                    fsoe_pkg::C_LC_X: stage_number(arg, 16, 1'b0);
                    fsoe_pkg::C_UC_X: stage_number(arg, 16, 1'b1);
                    fsoe_pkg::C_LC_S: ;
                    default: begin
                        for (int k = 3; k >= 0; k--) staged.push_back(BOMB_MARKER[k*8 +: 8]);
                    end
                endcase
            end else begin
                swallow = cr_seen && (ch == fsoe_pkg::C_LF || ch == fsoe_pkg::C_CR);
                cr_seen = 1'b0;
                if (swallow) begin
                    swallowed++;
                end else if (ch == fsoe_pkg::C_PCT) begin
                    in_fmt = 1'b1;
                end else if (ch == fsoe_pkg::C_CR) begin
                    staged.push_back(fsoe_pkg::C_LF);
                    cr_seen = 1'b1;
                end else begin
                    staged.push_back(ch);
                end
            end
            foreach (staged[i]) begin
                pending_bytes.push_back('{ch: staged[i], is_last: (i == staged.size() - 1)});
            end
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        // Compare one sent byte with the oldest expected byte.
        task check_byte(logic [7:0] ch, logic last);
            t_emitted want;
            bytes_checked++;
            if (pending_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h last %0b", ch, last));
                return;
            end
            want = pending_bytes.pop_front();
            if (ch !== want.ch) begin
                report_mismatch($sformatf("byte %02h, expected %02h", ch, want.ch));
            end
            if (last !== want.is_last) begin
                report_mismatch($sformatf("last %0b on byte %02h, expected %0b",
                                          last, ch, want.is_last));
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_fmt_char;
    logic [31:0] i_arg_value;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_out_char;
    logic        o_last;

    format_checker sb = new();

    // Sender and receiver coordination
    logic offering   = 1'b0;   // i_in_valid is currently driven high
    logic steady     = 1'b0;   // suppress sender gaps
    logic hold_out   = 1'b0;   // ask the receiver for one long hold-off
    logic holding    = 1'b0;   // the receiver is in its hold-off
    int   burst_left = 0;
    int   cycle_count = 0;

    format_string_output_engine u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_fmt_char  (i_fmt_char),
        .i_arg_value (i_arg_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_char  (o_out_char),
        .o_last      (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Check every byte taken by the receiver; values are the pre-edge ones.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_byte(o_out_char, o_last);
        end
    end

    // Abort a run that hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("cycle limit of %0d reached with %0d bytes outstanding",
                     CYCLE_LIMIT, sb.pending());
            $display("format_string_output_engine regression: fail");
            $finish;
        end
    end

    // Receiver: segments of random length, each with its own stall pattern,
    // plus one long hold-off on request so the engine backs up into its input.
    initial begin : receiver
        int       seg_len;
        t_rx_mode seg_mode;
        i_out_ready = 1'b0;
        forever begin
            if (hold_out) begin
                holding = 1'b1;
                repeat (HOLD_CYCLES) begin
                    @(posedge i_clk);
                    i_out_ready <= 1'b0;
                end
                holding  = 1'b0;
                hold_out = 1'b0;
            end else begin
                seg_len  = $urandom_range(5, 40);
                seg_mode = t_rx_mode'($urandom_range(0, 3));
                repeat (seg_len) begin
                    @(posedge i_clk);
                    case (seg_mode)
                        RX_OPEN:  i_out_ready <= 1'b1;
                        RX_COIN:  i_out_ready <= 1'($urandom_range(0, 1));
                        RX_SLOW:  i_out_ready <= ($urandom_range(0, 3) == 0);
                        default:  i_out_ready <= ($urandom_range(0, 7) != 0);
                    endcase
                end
            end
        end
    end

    // Offer one item and hold it until taken; then close the burst with a
    // random gap, or keep valid high for the next item.
    task automatic send_item(input logic [7:0] ch, input logic [31:0] arg);
        int gap;
        i_in_valid  <= 1'b1;
        i_fmt_char  <= ch;
        i_arg_value <= arg;
        offering = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.take_item(ch, arg);
        if (!steady) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 12);
                gap = $urandom_range(0, 6);
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    offering = 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    endtask

    task automatic send_conv(input logic [7:0] conv, input logic [31:0] arg);
        send_item(fsoe_pkg::C_PCT, $urandom);
        send_item(conv, arg);
    endtask

    // Drop valid, then wait on the clock until every queued byte has come out.
    task automatic wait_drain();
        if (offering) begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
        end
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Argument words biased toward zero, small values and the extremes.
    function automatic logic [31:0] pick_arg();
        logic [31:0] a;
        case ($urandom_range(0, 5))
            0:       a = '0;
            1:       a = $urandom_range(0, 20);
            2:       a = -$urandom_range(1, 20);
            3: begin
                case ($urandom_range(0, 2))
                    0:       a = INT_MIN;
                    1:       a = INT_MAX;
                    default: a = '1;
                endcase
            end
            default: a = $urandom;
        endcase
        return a;
    endfunction

    // One piece of a format string: mostly conversions and plain text,
    // with line ends, terminators and raw noise mixed in.
    task automatic send_segment();
        int          r;
        logic [7:0]  conv;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            case ($urandom_range(0, 7))
                0:       conv = fsoe_pkg::C_PCT;
                1:       conv = fsoe_pkg::C_LC_C;
                2, 3:    conv = fsoe_pkg::C_LC_D;
                4:       conv = fsoe_pkg::C_LC_X;
                5:       conv = fsoe_pkg::C_UC_X;
                6:       conv = fsoe_pkg::C_LC_S;
                default: conv = 8'($urandom_range(0, 255));
            endcase
            send_conv(conv, pick_arg());
        end else if (r < 60) begin
            send_item(8'($urandom_range(8'h20, 8'h7E)), $urandom);
        end else if (r < 70) begin
            send_item(fsoe_pkg::C_CR, $urandom);
            if ($urandom_range(0, 1)) begin
                send_item($urandom_range(0, 1) ? fsoe_pkg::C_LF : fsoe_pkg::C_CR, $urandom);
            end
        end else if (r < 75) begin
            send_item(fsoe_pkg::C_LF, $urandom);
        end else if (r < 80) begin
            send_item(fsoe_pkg::C_NUL, $urandom);
        end else begin
            send_item(8'($urandom_range(0, 255)), $urandom);
        end
    endtask

    initial begin : stimulus
        int  random_start;
        logic pressure_done;
        pressure_done = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_fmt_char  = '0;
        i_arg_value = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: literals, line-end folding, every conversion kind, %d at INT_MIN and zero.
        send_item(8'h41, 32'h0);
        send_item(8'hFF, 32'hFFFF_FFFF);
        send_item(fsoe_pkg::C_CR, 32'h0);
        send_item(fsoe_pkg::C_LF, 32'h0);          // swallowed after CR
        send_item(fsoe_pkg::C_CR, 32'h0);
        send_item(fsoe_pkg::C_CR, 32'h0);          // swallowed, does not rearm
        send_conv(fsoe_pkg::C_PCT, 32'h0);
        send_conv(fsoe_pkg::C_LC_C, 32'h1234_5641);
        send_conv(fsoe_pkg::C_LC_D, INT_MIN);
        send_conv(fsoe_pkg::C_LC_D, 32'h0);
        send_conv(fsoe_pkg::C_LC_X, 32'hFFFF_FFFF);
        send_conv(fsoe_pkg::C_UC_X, 32'hABCD_EF01);
        send_conv(fsoe_pkg::C_LC_S, 32'h5555_AAAA);
        send_conv(8'h71, 32'h0);         // unknown conversion gives the bomb marker
        send_conv(fsoe_pkg::C_NUL, 32'h0);         // terminator inside a conversion
        send_item(fsoe_pkg::C_CR, 32'h0);
        send_item(fsoe_pkg::C_NUL, 32'h0);         // terminator clears the pending CR
        send_item(fsoe_pkg::C_LF, 32'h0);

        // Random strings; partway through, drain fully, then hold the
        // receiver off while the sender pushes long conversions back to back.
        random_start = sb.items_seen;
        while (sb.items_seen < random_start + RANDOM_ITEMS) begin
            if (!pressure_done && sb.items_seen >= random_start + 40) begin
                wait_drain();
                hold_out = 1'b1;
                wait (holding);
                steady = 1'b1;
                repeat (5) send_conv(fsoe_pkg::C_LC_D, pick_arg());
                steady = 1'b0;
                pressure_done = 1'b1;
            end
            send_segment();
        end

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d format bytes: %0d conversions, %0d swallowed line ends",
                 sb.items_seen, sb.conversions, sb.swallowed);
        $display("checked %0d output bytes under random stalls and one long output hold-off",
                 sb.bytes_checked);
        if (sb.errors == 0) begin
            $display("format_string_output_engine regression: pass");
        end else begin
            $display("format_string_output_engine regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
